FILE: sv/rlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser package
// Shared widths, character codes, parse phases, result codes and the
// payload and state types of the range list parser.
// ----------------------------------------------------------------------------
package rlp_pkg;

    // Width of the accumulated numbers and of the emitted range ends.
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CHAR_WIDTH  = 8;

    // Characters that steer the parse.
    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_WIDTH-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

    // Parse phases.
    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_NUMBER  = 2'd1;
    localparam logic [1:0] PH_STOPPED = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_PAIR     = 2'd0;
    localparam logic [1:0] ST_ERROR    = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;

    // One input item.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  end_of_string;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_WIDTH-1:0] range_first;
        logic [OUT_WIDTH-1:0] range_second;
        logic                 last_of_string;
    } t_out_item;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] running_value;
        logic [VALUE_WIDTH-1:0] held_start;
        logic                   start_pending;
        logic                   at_first_char;
        logic [1:0]             parse_phase;
    } t_state;

endpackage

FILE: sv/rlp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser channels
// Valid/ready channels for the character items and the result items.
// ----------------------------------------------------------------------------
interface rlp_in_if;
    logic                             valid;
    logic                             ready;
    logic [rlp_pkg::CHAR_WIDTH-1:0]   character;
    logic                             end_of_string;

    modport source (output valid, output character, output end_of_string, input ready);
    modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

interface rlp_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [rlp_pkg::OUT_WIDTH-1:0]    range_first;
    logic [rlp_pkg::OUT_WIDTH-1:0]    range_second;
    logic                             last_of_string;

    modport source (output valid, output status, output range_first,
                    output range_second, output last_of_string, input ready);
    modport sink   (input valid, input status, input range_first,
                    input range_second, input last_of_string, output ready);
endinterface

FILE: sv/rlp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser step
// Combinational update for one character: next parser state and the
// result item, if the character causes one.
// ----------------------------------------------------------------------------
module rlp_step (
    input  rlp_pkg::t_state    i_state,
    input  rlp_pkg::t_in_item  i_item,
    output rlp_pkg::t_state    o_state,
    output logic               o_res_valid,
    output rlp_pkg::t_out_item o_res
);

    localparam int VW = rlp_pkg::VALUE_WIDTH;

    // Outcome of a character.
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_PAIR  = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    // Outcome of closing the number in progress.
    function automatic logic [1:0] close_kind(input logic [VW-1:0] run,
                                              input logic [VW-1:0] held,
                                              input logic          pend);
        logic [1:0] k;
        begin
            k = K_PAIR;
            if (run == '0) begin
                k = K_ERROR;
            end else if (pend && (run < held)) begin
                k = K_ERROR;
            end
            return k;
        end
    endfunction

    logic [rlp_pkg::CHAR_WIDTH-1:0] ch;
    logic                           is_digit;
    logic [VW-1:0]                  digit;
    logic [VW-1:0]                  run;
    logic [VW-1:0]                  held;
    logic                           pend;
    logic [1:0]                     phase;
    logic [1:0]                     kind;
    logic [VW-1:0]                  lo;
    logic [VW-1:0]                  hi;
    logic [VW-1:0]                  mul10;

    assign ch       = i_item.character;
    assign is_digit = (ch >= rlp_pkg::CH_ZERO) && (ch <= rlp_pkg::CH_NINE);
    assign digit    = VW'(4'(ch - rlp_pkg::CH_ZERO));
    // Times ten as two shifts and an add; the sum wraps at the value width.
    assign mul10    = (i_state.running_value << 3) + (i_state.running_value << 1) + digit;

    // Character step, then the end-of-string close.
    always_comb begin
        run   = i_state.running_value;
        held  = i_state.held_start;
        pend  = i_state.start_pending;
        phase = i_state.parse_phase;
        kind  = K_NONE;
        lo    = '0;
        hi    = '0;

        if (phase == rlp_pkg::PH_ERROR) begin
            kind = K_NONE;
        end else if (i_state.at_first_char && (ch == rlp_pkg::CH_COMMA)) begin
            kind = K_ERROR;
        end else if (phase != rlp_pkg::PH_STOPPED) begin
            if (is_digit) begin
                run   = mul10;
                phase = rlp_pkg::PH_NUMBER;
            end else if (ch == rlp_pkg::CH_COMMA) begin
                if (phase == rlp_pkg::PH_NUMBER) begin
                    kind  = close_kind(run, held, pend);
                    lo    = pend ? held : run;
                    hi    = run;
                    run   = '0;
                    pend  = 1'b0;
                    phase = rlp_pkg::PH_START;
                end else begin
                    kind = K_ERROR;
                end
            end else if (ch == rlp_pkg::CH_DASH) begin
                if ((phase != rlp_pkg::PH_NUMBER) || (run == '0) || pend) begin
                    kind = K_ERROR;
                end else begin
                    held  = run;
                    pend  = 1'b1;
                    run   = '0;
                    phase = rlp_pkg::PH_START;
                end
            end else if (ch == rlp_pkg::CH_NUL) begin
                if (phase == rlp_pkg::PH_NUMBER) begin
                    kind = close_kind(run, held, pend);
                    lo   = pend ? held : run;
                    hi   = run;
                    run  = '0;
                    pend = 1'b0;
                end
                phase = rlp_pkg::PH_STOPPED;
            end else begin
                if ((phase == rlp_pkg::PH_NUMBER) && (run != '0)) begin
                    phase = rlp_pkg::PH_STOPPED;
                end else begin
                    kind = K_ERROR;
                end
            end
        end
        if (kind == K_ERROR) begin
            phase = rlp_pkg::PH_ERROR;
        end

        // The last character closes any open number and always gives a result.
        if (i_item.end_of_string) begin
            if ((ch == rlp_pkg::CH_COMMA) || (phase == rlp_pkg::PH_ERROR)) begin
                kind = K_ERROR;
            end else if (phase == rlp_pkg::PH_NUMBER) begin
                kind = close_kind(run, held, pend);
                lo   = pend ? held : run;
                hi   = run;
            end
        end

        // Next state: back to the reset values after the last character.
        if (i_item.end_of_string) begin
            o_state.running_value = '0;
            o_state.held_start    = '0;
            o_state.start_pending = 1'b0;
            o_state.at_first_char = 1'b1;
            o_state.parse_phase   = rlp_pkg::PH_START;
        end else begin
            o_state.running_value = run;
            o_state.held_start    = held;
            o_state.start_pending = pend;
            o_state.at_first_char = 1'b0;
            o_state.parse_phase   = phase;
        end

        // Result item.
        o_res_valid          = i_item.end_of_string || (kind != K_NONE);
        o_res.last_of_string = i_item.end_of_string;
        if (kind == K_PAIR) begin
            o_res.status       = rlp_pkg::ST_PAIR;
            o_res.range_first  = rlp_pkg::OUT_WIDTH'(lo);
            o_res.range_second = rlp_pkg::OUT_WIDTH'(hi);
        end else begin
            o_res.status       = (kind == K_ERROR) ? rlp_pkg::ST_ERROR
                                                   : rlp_pkg::ST_FINISHED;
            o_res.range_first  = '0;
            o_res.range_second = '0;
        end
    end

endmodule

FILE: sv/range_list_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser
// Parses comma-separated decimal numbers and ranges, one character per item,
// and emits one (first, second) pair per list element.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one text character per item plus end_of_string on the last
//   character of a string. o_out carries results: status (pair, error or
//   finished), the range ends and last_of_string. A character gives at most
//   one result; the last character of a string always gives exactly one.
//   After an error result the consumer drops all pairs of that string.
//   An accepted character sits in the input register while the parse step
//   works out its result; when the character advances, the result, if any,
//   is loaded into the result register and offered on o_out from there.
//   Throughput: one character per cycle while results are taken, set by the
//   combinational update (multiply by ten, add, compare) of every character.
//   When the receiver stalls, the result register holds its item and the
//   input register keeps one more character; i_in.ready then drops.
//   Reset clears both registers' valid flags and returns the parser to the
//   start of a string.
// ----------------------------------------------------------------------------
module range_list_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rlp_in_if.sink        i_in,
    rlp_out_if.source     o_out
);

    logic               r_in_valid;
    rlp_pkg::t_in_item  r_in;
    rlp_pkg::t_state    r_state;
    logic               r_out_valid;
    rlp_pkg::t_out_item r_out;

    rlp_pkg::t_state    n_state;
    logic               step_res_valid;
    rlp_pkg::t_out_item step_res;
    logic               advance;

    // The held character moves on once the result register can take a result.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    rlp_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.character     <= i_in.character;
            r_in.end_of_string <= i_in.end_of_string;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.running_value <= '0;
            r_state.held_start    <= '0;
            r_state.start_pending <= 1'b0;
            r_state.at_first_char <= 1'b1;
            r_state.parse_phase   <= rlp_pkg::PH_START;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.range_first    = r_out.range_first;
    assign o_out.range_second   = r_out.range_second;
    assign o_out.last_of_string = r_out.last_of_string;

endmodule

FILE: bench/rlp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser result checker
// Watches both channels of the parser. Every accepted character goes through
// a local model of the parse, and each result that the character causes is
// queued. Every accepted result is compared field by field with the oldest
// queued one. The failure count and the number of outstanding results are
// passed to the testbench top.
// ----------------------------------------------------------------------------
module rlp_result_checker
    import rlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rlp_in_if    i_in,
    rlp_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = 10;

    // What a character does to the list: nothing, close an element, or fail.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PAIR,
        KIND_ERROR
    } parse_kind_e;

    t_state    parse_state;
    t_out_item expected_results[$];
    int        fail_total = 0;

    // Return the parse to the start of a string.
    function automatic void clear_parse_state();
        parse_state.running_value = '0;
        parse_state.held_start    = '0;
        parse_state.start_pending = 1'b0;
        parse_state.at_first_char = 1'b1;
        parse_state.parse_phase   = PH_START;
    endfunction

    // Finish the number in progress as a single value or as a range end.
    function automatic parse_kind_e close_number(inout logic [OUT_WIDTH-1:0] lo,
                                                 inout logic [OUT_WIDTH-1:0] hi);
        parse_kind_e kind;
        kind = KIND_PAIR;
        if (parse_state.running_value == '0) begin
            kind = KIND_ERROR;
        end else if (parse_state.start_pending) begin
            if (parse_state.running_value < parse_state.held_start) begin
                kind = KIND_ERROR;
            end else begin
                lo = parse_state.held_start;
                hi = parse_state.running_value;
            end
        end else begin
            lo = parse_state.running_value;
            hi = parse_state.running_value;
        end
        parse_state.running_value = '0;
        parse_state.start_pending = 1'b0;
        parse_state.parse_phase   = PH_START;
        return kind;
    endfunction

    // Advance the parse by one character and work out the result, if any.
    function automatic void parse_char(input  logic [CHAR_WIDTH-1:0] ch,
                                       input  logic                  eos,
                                       output bit                    emit,
                                       output t_out_item             res);
        parse_kind_e          kind;
        logic [OUT_WIDTH-1:0] lo;
        logic [OUT_WIDTH-1:0] hi;
        kind = KIND_NONE;
        lo   = '0;
        hi   = '0;
        emit = 1'b0;
        res  = '0;

        if (parse_state.parse_phase == PH_ERROR) begin
            kind = KIND_NONE;
        end else if (parse_state.at_first_char && ch == CH_COMMA) begin
            kind = KIND_ERROR;
        end else if (parse_state.parse_phase != PH_STOPPED) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                parse_state.running_value = parse_state.running_value * DECIMAL_BASE
                                          + VALUE_WIDTH'(ch - CH_ZERO);
                parse_state.parse_phase = PH_NUMBER;
            end else if (ch == CH_COMMA) begin
                if (parse_state.parse_phase == PH_NUMBER) begin
                    kind = close_number(lo, hi);
                end else begin
                    kind = KIND_ERROR;
                end
            end else if (ch == CH_DASH) begin
                if (parse_state.parse_phase != PH_NUMBER || parse_state.running_value == '0
                        || parse_state.start_pending) begin
                    kind = KIND_ERROR;
                end else begin
                    parse_state.held_start    = parse_state.running_value;
                    parse_state.start_pending = 1'b1;
                    parse_state.running_value = '0;
                    parse_state.parse_phase   = PH_START;
                end
            end else if (ch == CH_NUL) begin
                // A NUL byte ends the text early; a pending number still closes.
                if (parse_state.parse_phase == PH_NUMBER) begin
                    kind = close_number(lo, hi);
                end
                parse_state.parse_phase = PH_STOPPED;
            end else begin
                // Any other byte stops quietly after a number, else it is an error.
                if (parse_state.parse_phase == PH_NUMBER && parse_state.running_value != '0) begin
                    parse_state.parse_phase = PH_STOPPED;
                end else begin
                    kind = KIND_ERROR;
                end
            end
        end
        parse_state.at_first_char = 1'b0;
        if (kind == KIND_ERROR) begin
            parse_state.parse_phase = PH_ERROR;
        end

        if (eos) begin
            // The last character always gives exactly one result.
            if (ch == CH_COMMA || parse_state.parse_phase == PH_ERROR) begin
                kind = KIND_ERROR;
            end else if (parse_state.parse_phase == PH_NUMBER) begin
                kind = close_number(lo, hi);
            end
            emit = 1'b1;
            res.status = (kind == KIND_PAIR)  ? ST_PAIR :
                         (kind == KIND_ERROR) ? ST_ERROR : ST_FINISHED;
            res.last_of_string = 1'b1;
            clear_parse_state();
        end else if (kind != KIND_NONE) begin
            emit = 1'b1;
            res.status = (kind == KIND_PAIR) ? ST_PAIR : ST_ERROR;
            res.last_of_string = 1'b0;
        end
        if (res.status == ST_PAIR) begin
            res.range_first  = lo;
            res.range_second = hi;
        end
    endfunction

    // Compare one field of a result and report a mismatch.
    function automatic void check_field(input string                name,
                                        input logic [OUT_WIDTH-1:0] want,
                                        input logic [OUT_WIDTH-1:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Predict on every accepted character and check every accepted result.
    always @(posedge i_clk) begin : watch
        bit        emit;
        t_out_item predicted;
        t_out_item got;
        if (!i_rst_n) begin
            clear_parse_state();
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                parse_char(i_in.character, i_in.end_of_string, emit, predicted);
                if (emit) begin
                    expected_results.insert(expected_results.size(), predicted);
                end
            end
            if (i_out.valid && i_out.ready) begin
                got.status         = i_out.status;
                got.range_first    = i_out.range_first;
                got.range_second   = i_out.range_second;
                got.last_of_string = i_out.last_of_string;
                if (expected_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, got.status, got.range_first, got.range_second,
                             got.last_of_string);
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("status", OUT_WIDTH'(predicted.status), OUT_WIDTH'(got.status));
                    check_field("range_first", predicted.range_first, got.range_first);
                    check_field("range_second", predicted.range_second, got.range_second);
                    check_field("last_of_string", OUT_WIDTH'(predicted.last_of_string),
                                OUT_WIDTH'(got.last_of_string));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: bench/tb_range_list_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range list parser testbench
// Drives strings of characters into the parser: a directed set covering
// error and stop conditions, then random lists that are mostly well formed
// with some broken lists and noise. Both channels idle at random, the result
// side holds off for a long stretch once, and the sender pauses until all
// results are in between phases. The result checker does the comparison.
// ----------------------------------------------------------------------------
module tb_range_list_parser;
    import rlp_pkg::*;

    localparam int RANDOM_CHARS = 1600;
    localparam int PHASES       = 4;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;
    localparam int TIMEOUT_NS   = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    logic [CHAR_WIDTH-1:0] line_buf[$];
    int                    chars_sent    = 0;
    bit                    tx_idle_on    = 1'b0;
    bit                    rx_idle_on    = 1'b0;
    int                    rx_hold_cycles = 0;

    rlp_in_if  in_ch();
    rlp_out_if out_ch();

    range_list_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rlp_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Run time limit.
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 10)) : 0;
    endfunction

    // Add one character at the end of the line buffer.
    function automatic void append_char(input logic [CHAR_WIDTH-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            append_char(s[k]);
        end
    endfunction

    // Decimal text of a number, mostly small, sometimes at or past the limits.
    function automatic string random_number(output logic [VALUE_WIDTH-1:0] value);
        int    pick;
        string digits;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            value = $urandom_range(1, 99);
        end else if (pick < 75) begin
            value = $urandom_range(100, 99999);
        end else if (pick < 87) begin
            value = $urandom;
        end else if (pick < 90) begin
            value = '0;
        end else if (pick < 95) begin
            value = '1;
        end else begin
            // Digit strings that wrap past 2^32 to zero or one.
            value = $urandom_range(0, 1);
            return (value == 0) ? "4294967296" : "8589934593";
        end
        digits = $sformatf("%0d", value);
        if ($urandom_range(0, 9) == 0) begin
            digits = {"00", digits};
        end
        return digits;
    endfunction

    // Fill the line buffer with one random string.
    function automatic void build_random_line();
        int                     r;
        int                     elems;
        string                  a_txt;
        string                  b_txt;
        string                  tmp;
        logic [VALUE_WIDTH-1:0] a_val;
        logic [VALUE_WIDTH-1:0] b_val;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            elems = $urandom_range(1, 4);
            for (int e = 0; e < elems; e++) begin
                if (e > 0) begin
                    append_char(CH_COMMA);
                end
                a_txt = random_number(a_val);
                if ($urandom_range(0, 2) == 0) begin
                    b_txt = random_number(b_val);
                    // Ranges are mostly ascending.
                    if (b_val < a_val && $urandom_range(0, 7) != 0) begin
                        tmp   = a_txt;
                        a_txt = b_txt;
                        b_txt = tmp;
                    end
                    push_text(a_txt);
                    append_char(CH_DASH);
                    push_text(b_txt);
                end else begin
                    push_text(a_txt);
                end
            end
            // Now and then break the list.
            r = $urandom_range(0, 19);
            if (r == 0) begin
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (r == 1) begin
                append_char(CH_COMMA);
            end else if (r == 2) begin
                append_char(CH_DASH);
            end else if (r == 3) begin
                append_char(8'($urandom_range(0, 255)));
            end
        end else begin
            // Noise built from the characters that matter and random bytes.
            for (int k = $urandom_range(1, 6); k > 0; k--) begin
                case ($urandom_range(0, 4))
                    0: append_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    1: append_char(CH_COMMA);
                    2: append_char(CH_DASH);
                    3: append_char(CH_NUL);
                    default: append_char(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endfunction

    // Offer one character after a random gap and wait until it is taken.
    task automatic send_char(input logic [CHAR_WIDTH-1:0] ch, input logic eos);
        int gap;
        gap = draw_gap(tx_idle_on);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.character     <= ch;
        in_ch.end_of_string <= eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Send the buffered string with the end flag on its last character.
    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++) begin
            send_char(line_buf[k], k == line_buf.size() - 1);
        end
        chars_sent += line_buf.size();
        line_buf.delete();
    endtask

    // Stop sending until every predicted result has been received.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls per item, plus one long hold on request.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(rx_idle_on) + rx_hold_cycles;
            rx_hold_cycles = 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Reset, stimulus and verdict.
    initial begin
        int target;
        int waited;
        i_rst_n              = 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.character     <= '0;
        in_ch.end_of_string <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: ranges, singles, and error and stop conditions.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        push_text("1-3,5");
        send_line();
        push_text(",");
        send_line();
        push_text("0");
        send_line();
        push_text("3-1");
        send_line();
        push_text("1--");
        send_line();
        push_text("4-");
        send_line();
        push_text("7");
        append_char(8'hFF);
        push_text("9");
        send_line();
        push_text("x");
        send_line();
        push_text("9");
        append_char(CH_NUL);
        push_text("z");
        send_line();
        push_text("5,");
        send_line();
        wait_drained();

        // Random phases with different idling on each side.
        for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            tx_idle_on = (phase_idx == 1) || (phase_idx == 2);
            rx_idle_on = (phase_idx == 1) || (phase_idx == 3);
            if (phase_idx == 2) begin
                rx_hold_cycles = LONG_HOLD;
            end
            target = chars_sent + RANDOM_CHARS / PHASES;
            while (chars_sent < target) begin
                build_random_line();
                send_line();
            end
            wait_drained();
        end

        // Final drain, then a tail wait to catch stray results.
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0) begin
            $display("CHECKS FAILED");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (fail_count == 0 && pending == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
        end
        $finish;
    end

endmodule

FILE: range_list_parser.f
sv/rlp_pkg.sv
sv/rlp_if.sv
sv/rlp_step.sv
sv/range_list_parser.sv
bench/rlp_result_checker.sv
bench/tb_range_list_parser.sv
